// ===== rtl/tib_pkg.sv =====
// Package for the TLB invalidation batcher: sizes, codes and the
// command and status structs shared by the controller and the datapath.
// Depends on nothing.
package tib_pkg;

   // Queue and address geometry.
   localparam int QUEUE_DEPTH = 32;
   localparam int PAGE_BITS   = 12;
   localparam int FAR_BITS    = 21;

   localparam int ADDR_W  = 64;
   localparam int FRAME_W = 40;
   localparam int COUNT_W = 52;
   localparam int SHIFT_W = 6;

   // Queue index and fill count widths.
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_BITS;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_REMOVE = 2'd0,
      ACT_TABLE  = 2'd1,
      ACT_FLUSH  = 2'd2,
      ACT_NONE   = 2'd3
   } tib_action_type;

   // Response kinds.
   localparam logic KIND_RANGE   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic prep;
      logic enqueue_only;
      logic update;
      logic load_range;
      logic load_release;
      logic clear_batch;
   } tib_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      tib_action_type action;
      logic           covers;
      logic           flush_needed;
      logic           active;
      logic           queue_full;
      logic           queue_empty;
      logic           last_release;
      logic           out_free;
   } tib_status_type;

endpackage

// ===== rtl/tib_datapath.sv =====
// Datapath of the TLB invalidation batcher: request registers, batch
// bounds, the deferred page queue memory and the response register.
// Depends on tib_pkg.
module tib_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  tib_pkg::tib_cmd_type             cmd,
   output tib_pkg::tib_status_type          status,
   input  logic [1:0]                       req_action,
   input  logic [tib_pkg::ADDR_W-1:0]       req_address,
   input  logic                             req_has_page,
   input  logic [tib_pkg::FRAME_W-1:0]      req_page_ref,
   input  logic [tib_pkg::ADDR_W-1:0]       req_region_end,
   input  logic [tib_pkg::SHIFT_W-1:0]      req_span_shift,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic                             rsp_kind,
   output logic [tib_pkg::ADDR_W-1:0]       rsp_range_start,
   output logic [tib_pkg::COUNT_W-1:0]      rsp_page_count,
   output logic [tib_pkg::FRAME_W-1:0]      rsp_released_page,
   output logic                             rsp_last
);

   // Latched request.
   logic [1:0]                   action_ff;
   logic [tib_pkg::ADDR_W-1:0]   address_ff;
   logic                         has_page_ff;
   logic [tib_pkg::FRAME_W-1:0]  page_ref_ff;
   logic [tib_pkg::ADDR_W-1:0]   region_end_ff;
   logic [tib_pkg::SHIFT_W-1:0]  span_shift_ff;

   // Prepared removal.
   logic [tib_pkg::ADDR_W-1:0]   eff_addr_ff, eff_addr_in;
   logic                         with_page_ff, with_page_in;
   logic                         covers_ff, covers_in;

   // Batch state.
   logic                         active_ff, active_in;
   logic [tib_pkg::ADDR_W-1:0]   start_ff, start_in;
   logic [tib_pkg::ADDR_W-1:0]   end_ff, end_in;
   logic [tib_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic [tib_pkg::QCNT_W-1:0]   idx_ff, idx_in;
   logic [tib_pkg::QCNT_W-1:0]   idx_next;

   // Queue memory.
   logic [tib_pkg::FRAME_W-1:0]  mem [tib_pkg::QUEUE_DEPTH];
   logic [tib_pkg::FRAME_W-1:0]  rd_data_ff;
   logic                         wr_en;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [tib_pkg::ADDR_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [tib_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [tib_pkg::FRAME_W-1:0]  rsp_page_ff, rsp_page_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [tib_pkg::ADDR_W-1:0]   span_mask;
   logic [tib_pkg::ADDR_W-1:0]   base;
   logic [tib_pkg::ADDR_W-1:0]   lo_diff, hi_diff, width_diff, count_wide;
   logic                         far_lo, far_hi, full, out_free;

   // Region base, the coverage test for a table removal, and the prepared address and page flag.
   always_comb begin
      span_mask   = (tib_pkg::ADDR_W'(1) << span_shift_ff) - tib_pkg::ADDR_W'(1);
      base        = address_ff & ~span_mask;
      covers_in   = active_ff && (base <= end_ff) && (start_ff <= region_end_ff);
      if (action_ff == tib_pkg::ACT_TABLE) begin
         eff_addr_in  = region_end_ff - tib_pkg::PAGE_BYTES;
         with_page_in = 1'b1;
      end else begin
         eff_addr_in  = address_ff;
         with_page_in = has_page_ff;
      end
   end

   // Distance tests on the prepared address (signed mod 2^64), full, page count, output free.
   always_comb begin
      lo_diff = start_ff - eff_addr_ff;
      hi_diff = eff_addr_ff - end_ff;
      far_lo  = !lo_diff[tib_pkg::ADDR_W-1] && (|lo_diff[tib_pkg::ADDR_W-2:tib_pkg::FAR_BITS]);
      far_hi  = !hi_diff[tib_pkg::ADDR_W-1] && (|hi_diff[tib_pkg::ADDR_W-2:tib_pkg::FAR_BITS]);
      full    = (count_ff == tib_pkg::QCNT_W'(tib_pkg::QUEUE_DEPTH));
      width_diff = end_ff - start_ff;
      count_wide = width_diff >> tib_pkg::PAGE_BITS;
      idx_next   = idx_ff + tib_pkg::QCNT_W'(1);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Batch bounds, queue fill and release index.
   always_comb begin
      active_in = active_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      if (cmd.clear_batch) begin
         active_in = 1'b0;
         count_in  = '0;
      end
      if (cmd.update) begin
         if (!active_ff) begin
            start_in  = eff_addr_ff;
            end_in    = eff_addr_ff + tib_pkg::PAGE_BYTES;
            active_in = 1'b1;
         end else if (eff_addr_ff < start_ff) begin
            start_in = eff_addr_ff;
         end else if (eff_addr_ff >= end_ff) begin
            end_in = eff_addr_ff + tib_pkg::PAGE_BYTES;
         end
      end
      if ((cmd.update && with_page_ff && !full) || (cmd.enqueue_only && !full)) begin
         wr_en    = 1'b1;
         count_in = count_ff + tib_pkg::QCNT_W'(1);
      end
      if (cmd.load_range) begin
         idx_in = '0;
      end else if (cmd.load_release) begin
         idx_in = idx_next;
      end else begin
         idx_in = idx_ff;
      end
   end

   // Response register next value.
   always_comb begin
      rsp_kind_in  = rsp_kind_ff;
      rsp_start_in = rsp_start_ff;
      rsp_count_in = rsp_count_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_range) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = tib_pkg::KIND_RANGE;
         rsp_start_in = start_ff;
         rsp_count_in = count_wide[tib_pkg::COUNT_W-1:0];
         rsp_page_in  = '0;
         rsp_last_in  = (count_ff == '0);
      end else if (cmd.load_release) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = tib_pkg::KIND_RELEASE;
         rsp_start_in = '0;
         rsp_count_in = '0;
         rsp_page_in  = rd_data_ff;
         rsp_last_in  = (idx_next == count_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff     <= req_action;
         address_ff    <= req_address;
         has_page_ff   <= req_has_page;
         page_ref_ff   <= req_page_ref;
         region_end_ff <= req_region_end;
         span_shift_ff <= req_span_shift;
      end
      if (cmd.prep) begin
         eff_addr_ff  <= eff_addr_in;
         with_page_ff <= with_page_in;
         covers_ff    <= covers_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_start_ff <= rsp_start_in;
      rsp_count_ff <= rsp_count_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Queue memory; the read follows the next index so data lines up with idx_ff.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[tib_pkg::QIDX_W-1:0]] <= page_ref_ff;
      end
      rd_data_ff <= mem[idx_in[tib_pkg::QIDX_W-1:0]];
   end

   // Status toward the controller.
   always_comb begin
      status.action       = tib_pkg::tib_action_type'(action_ff);
      status.covers       = covers_ff;
      status.flush_needed = active_ff && (far_lo || far_hi || (with_page_ff && full));
      status.active       = active_ff;
      status.queue_full   = full;
      status.queue_empty  = (count_ff == '0);
      status.last_release = (idx_next == count_ff);
      status.out_free     = out_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_range_start   = rsp_start_ff;
   assign rsp_page_count    = rsp_count_ff;
   assign rsp_released_page = rsp_page_ff;
   assign rsp_last          = rsp_last_ff;

   // The queue never holds more pages than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tib_pkg::QCNT_W'(tib_pkg::QUEUE_DEPTH))
      else $error("pending count exceeds queue depth");

   // A response is loaded only when the output register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_range || cmd.load_release) |-> out_free)
      else $error("response loaded over a waiting response");

   // A release reads only a filled queue entry.
   a_release_idx: assert property (@(posedge clock) disable iff (reset)
      cmd.load_release |-> (idx_ff < count_ff))
      else $error("release index beyond pending count");

   // The final release of a flush leaves the queue empty and the batch closed.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_release && rsp_last_in) |=> (count_ff == '0 && !active_ff))
      else $error("flush did not clear the batch");

endmodule

// ===== rtl/tib_ctrl.sv =====
// Controller of the TLB invalidation batcher: sequences request intake,
// the flush decision, range and release responses, and the batch update.
// Depends on tib_pkg.
module tib_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tib_pkg::tib_status_type status,
   output tib_pkg::tib_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DECIDE,
      S_RANGE,
      S_RELEASE,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      post_update_ff, post_update_in;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      post_update_in = post_update_ff;
      cmd            = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (status.action)
               tib_pkg::ACT_REMOVE, tib_pkg::ACT_TABLE: begin
                  if (status.action == tib_pkg::ACT_TABLE && status.covers &&
                      !status.queue_full) begin
                     // Region already covered: only hold back its page.
                     cmd.enqueue_only = 1'b1;
                     state_in         = S_IDLE;
                  end else if (status.flush_needed) begin
                     post_update_in = 1'b1;
                     state_in       = S_RANGE;
                  end else begin
                     state_in = S_UPDATE;
                  end
               end
               tib_pkg::ACT_FLUSH: begin
                  post_update_in = 1'b0;
                  state_in       = status.active ? S_RANGE : S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RANGE: begin
            if (status.out_free) begin
               cmd.load_range = 1'b1;
               if (status.queue_empty) begin
                  cmd.clear_batch = 1'b1;
                  state_in        = post_update_ff ? S_UPDATE : S_IDLE;
               end else begin
                  state_in = S_RELEASE;
               end
            end
         end
         S_RELEASE: begin
            if (status.out_free) begin
               cmd.load_release = 1'b1;
               if (status.last_release) begin
                  cmd.clear_batch = 1'b1;
                  state_in        = post_update_ff ? S_UPDATE : S_IDLE;
               end
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         post_update_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         post_update_ff <= post_update_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== rtl/tlb_invalidate_batcher.sv =====
// TLB invalidation batcher: one request at a time, taken only in the idle state.
// A request is latched, prepared and decided before the first response is loaded;
// a flush then gives one response per cycle while rsp_stall is low (range plus up
// to 32 releases, read one queue entry a cycle).
// Reset clears the batch flag, bounds, fill count and output; the page queue
// memory is not cleared, only entries below the fill count are read.
module tlb_invalidate_batcher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [tib_pkg::ADDR_W-1:0]  req_address,
   input  logic                        req_has_page,
   input  logic [tib_pkg::FRAME_W-1:0] req_page_ref,
   input  logic [tib_pkg::ADDR_W-1:0]  req_region_end,
   input  logic [tib_pkg::SHIFT_W-1:0] req_span_shift,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [tib_pkg::ADDR_W-1:0]  rsp_range_start,
   output logic [tib_pkg::COUNT_W-1:0] rsp_page_count,
   output logic [tib_pkg::FRAME_W-1:0] rsp_released_page,
   output logic                        rsp_last
);

   tib_pkg::tib_cmd_type    cmd;
   tib_pkg::tib_status_type status;

   // Sequencer.
   tib_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Batch state, queue and response register.
   tib_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_address       (req_address),
      .req_has_page      (req_has_page),
      .req_page_ref      (req_page_ref),
      .req_region_end    (req_region_end),
      .req_span_shift    (req_span_shift),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_range_start   (rsp_range_start),
      .rsp_page_count    (rsp_page_count),
      .rsp_released_page (rsp_released_page),
      .rsp_last          (rsp_last)
   );

endmodule
